@@ src/nggp_pkg.sv @@
package nggp_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_POINT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SOUTH  = 8'h53;
  localparam logic [7:0] CHAR_WEST   = 8'h57;

  // number reader phase
  localparam logic [1:0] PH_WHOLE = 2'd0;
  localparam logic [1:0] PH_FRAC  = 2'd1;
  localparam logic [1:0] PH_STOP  = 2'd2;

  localparam int unsigned PREFIX_LEN = 6;
  localparam int unsigned NUM_PREFIX = 3;
  localparam logic [2:0]  MAX_COMMAS = 3'd6;
  localparam logic [4:0]  FIELD_SAT  = 5'd31;

  localparam logic [2:0]  LAT_COMMA  = 3'd2;
  localparam logic [2:0]  LAT_HEM_COMMA = 3'd3;
  localparam logic [2:0]  LON_COMMA  = 3'd4;
  localparam logic [2:0]  LON_HEM_COMMA = 3'd5;

  localparam int unsigned WHOLE_W = 17;
  localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 17'd99999;

  // ddmm split: floor(x/100) = (x * RECIP_100) >> 24, exact for x < 199728
  localparam logic [17:0] RECIP_100 = 18'd167773;
  // floor(n/60) = (n * RECIP_60) >> 36, exact for n < 2^36/44
  localparam logic [30:0] RECIP_60  = 31'd1145324613;

  localparam logic [23:0] E7 = 24'd10000000;

  localparam int unsigned DEG_W  = 10;  // up to 999
  localparam int unsigned MIN_W  = 7;   // up to 99
  localparam int unsigned NUM_W  = 30;  // minutes * 1e7, below 1e9
  localparam int unsigned MINQ_W = 24;  // minutes * 1e7 / 60
  localparam int unsigned MAG_W  = 34;
  localparam int unsigned OUT_W  = 35;

  function automatic logic [23:0] pow10(input int n);
    logic [23:0] r;
    case (n)
      0: r = 24'd1;
      1: r = 24'd10;
      2: r = 24'd100;
      3: r = 24'd1000;
      4: r = 24'd10000;
      5: r = 24'd100000;
      6: r = 24'd1000000;
      7: r = 24'd10000000;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  // "$GPGGA", "$BDGGA", "$GNGGA"
  function automatic logic [7:0] prefix_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0: c = 8'h24;
      3'd1: c = (k == 2'd1) ? 8'h42 : 8'h47;
      3'd2: c = (k == 2'd0) ? 8'h50 : ((k == 2'd1) ? 8'h44 : 8'h4E);
      3'd3: c = 8'h47;
      3'd4: c = 8'h47;
      3'd5: c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ src/nmea_gga_position_parser.sv @@
// NMEA GGA position parser. Takes one received character per item and, when
// CR or LF closes a line that starts with $GPGGA, $BDGGA or $GNGGA and holds
// at least six commas, gives one result: latitude and longitude in signed
// units of 1e-7 degree (ddmm.mmmm converted exactly and truncated, negative
// for S and W), the character after comma 3 and after comma 5, and has_fix
// when both positions are nonzero. Lines beyond LINE_CAPACITY-1 characters
// keep their first part only; the CR/LF still closes them. Rate: one
// character per cycle while in_ready_o is high. Each character updates the
// line state; a closing character hands the captured fields to a
// seven-stage conversion pipeline (split into degrees and minutes, scale,
// divide by 60 through a reciprocal multiply, add, sign). Stages collapse
// bubbles, and rx_byte is refused only when every conversion stage holds
// a result the sink has not taken.
module nmea_gga_position_parser #(
  parameter int unsigned LINE_CAPACITY   = 128,
  parameter int unsigned FIELD_CHARS     = 19,
  parameter int unsigned FRACTION_DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [34:0] latitude_e7_o,
  output logic signed [34:0] longitude_e7_o,
  output logic [7:0]  lat_hemisphere_o,
  output logic [7:0]  lon_hemisphere_o,
  output logic        has_fix_o
);
  import nggp_pkg::*;

  localparam int unsigned KW     = $clog2(LINE_CAPACITY);
  localparam int unsigned FRAC_W = $clog2(10 ** FRACTION_DIGITS);
  localparam int unsigned FDW    = $clog2(FRACTION_DIGITS + 1);
  localparam logic [23:0] FRAC_SCALE = pow10(7 - FRACTION_DIGITS);
  localparam int unsigned NST    = 7;  // conversion stages incl. output register

  // ---------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------
  logic [KW-1:0]      kept_q, kept_d;
  logic [2:0]         prefix_q, prefix_d;
  logic [2:0]         comma_q, comma_d;
  logic [4:0]         flen_q, flen_d;
  logic [1:0]         phase_q, phase_d;
  logic [WHOLE_W-1:0] whole_q [2];
  logic [WHOLE_W-1:0] whole_d [2];
  logic [FRAC_W-1:0]  frac_q [2];   // kept pre-scaled to FRACTION_DIGITS places
  logic [FRAC_W-1:0]  frac_d [2];
  logic [FDW-1:0]     fdig_q [2];
  logic [FDW-1:0]     fdig_d [2];
  logic [7:0]         hem_q [2];
  logic [7:0]         hem_d [2];

  // Pipeline handshake
  logic [NST-1:0] sv_q, sv_d, mv, free;

  logic in_acc, is_term, is_digit, emit;
  logic [3:0] digit;
  logic       lane_act, lane;
  logic [WHOLE_W-1:0] w_sel;
  logic [FRAC_W-1:0]  f_sel;
  logic [FDW-1:0]     fd_sel;
  logic [19:0]        w_next;
  logic [27:0]        f_add;

  assign in_acc   = in_valid_i && in_ready_o;
  assign is_term  = (rx_byte_i == CHAR_CR) || (rx_byte_i == CHAR_LF);
  assign is_digit = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
  assign digit    = is_digit ? 4'(rx_byte_i - CHAR_ZERO) : 4'd0;
  assign emit     = in_acc && is_term && (kept_q != '0) && (prefix_q != 3'd0) &&
                    (kept_q >= KW'(PREFIX_LEN)) && (comma_q >= MAX_COMMAS);

  // lat field after comma 2, lon field after comma 4
  assign lane_act = (comma_q == LAT_COMMA) || (comma_q == LON_COMMA);
  assign lane     = (comma_q == LON_COMMA);
  assign w_sel    = whole_q[lane];
  assign f_sel    = frac_q[lane];
  assign fd_sel   = fdig_q[lane];
  assign w_next   = 20'(w_sel) * 20'd10 + 20'(digit);
  assign f_add    = 28'(digit) *
                    28'(pow10(int'(FRACTION_DIGITS) - 1 - int'(fd_sel)));

  always_comb begin
    kept_d   = kept_q;
    prefix_d = prefix_q;
    comma_d  = comma_q;
    flen_d   = flen_q;
    phase_d  = phase_q;
    whole_d  = whole_q;
    frac_d   = frac_q;
    fdig_d   = fdig_q;
    hem_d    = hem_q;
    if (in_acc) begin
      if (is_term) begin
        if (kept_q != '0) begin
          kept_d   = '0;
          prefix_d = '1;
          comma_d  = '0;
          flen_d   = '0;
          phase_d  = PH_WHOLE;
          for (int i = 0; i < 2; i++) begin
            whole_d[i] = '0;
            frac_d[i]  = '0;
            fdig_d[i]  = '0;
            hem_d[i]   = '0;
          end
        end
      end else if (kept_q < KW'(LINE_CAPACITY - 1)) begin
        kept_d = kept_q + 1'b1;
        if (kept_q < KW'(PREFIX_LEN)) begin
          for (int k = 0; k < NUM_PREFIX; k++) begin
            if (rx_byte_i != prefix_char(2'(k), kept_q[2:0])) prefix_d[k] = 1'b0;
          end
        end
        if (flen_q == '0) begin
          if (comma_q == LAT_HEM_COMMA) hem_d[0] = rx_byte_i;
          else if (comma_q == LON_HEM_COMMA) hem_d[1] = rx_byte_i;
        end
        if (rx_byte_i == CHAR_COMMA) begin
          if (comma_q < MAX_COMMAS) comma_d = comma_q + 1'b1;
          flen_d  = '0;
          phase_d = PH_WHOLE;
        end else begin
          if (flen_q < 5'(FIELD_CHARS) && lane_act) begin
            case (phase_q)
              PH_WHOLE: begin
                if (is_digit) begin
                  whole_d[lane] = (w_next > 20'(WHOLE_LIMIT)) ? WHOLE_LIMIT :
                                  w_next[WHOLE_W-1:0];
                end else if (rx_byte_i == CHAR_POINT) begin
                  phase_d = PH_FRAC;
                end else begin
                  phase_d = PH_STOP;
                end
              end
              PH_FRAC: begin
                if (is_digit) begin
                  if (fd_sel < FDW'(FRACTION_DIGITS)) begin
                    frac_d[lane] = f_sel + f_add[FRAC_W-1:0];
                    fdig_d[lane] = fd_sel + 1'b1;
                  end
                end else begin
                  phase_d = PH_STOP;
                end
              end
              default: ;
            endcase
          end
          if (flen_q < FIELD_SAT) flen_d = flen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q   <= '0;
      prefix_q <= '1;
      comma_q  <= '0;
      flen_q   <= '0;
      phase_q  <= PH_WHOLE;
      for (int i = 0; i < 2; i++) begin
        whole_q[i] <= '0;
        frac_q[i]  <= '0;
        fdig_q[i]  <= '0;
        hem_q[i]   <= '0;
      end
    end else begin
      kept_q   <= kept_d;
      prefix_q <= prefix_d;
      comma_q  <= comma_d;
      flen_q   <= flen_d;
      phase_q  <= phase_d;
      whole_q  <= whole_d;
      frac_q   <= frac_d;
      fdig_q   <= fdig_d;
      hem_q    <= hem_d;
    end
  end

  // ---------------------------------------------------------------------
  // Conversion pipeline; lane 0 latitude, lane 1 longitude.
  // A stage moves when it holds an item and the next one is free.
  // ---------------------------------------------------------------------
  always_comb begin
    mv[NST-1]   = sv_q[NST-1] && out_ready_i;
    free[NST-1] = !sv_q[NST-1] || mv[NST-1];
    for (int s = NST - 2; s >= 0; s--) begin
      mv[s]   = sv_q[s] && free[s+1];
      free[s] = !sv_q[s] || mv[s];
    end
    sv_d = sv_q & ~mv;
    if (emit) sv_d[0] = 1'b1;
    for (int s = 1; s < NST; s++) begin
      if (mv[s-1]) sv_d[s] = 1'b1;
    end
  end

  assign in_ready_o = free[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= '0;
    else         sv_q <= sv_d;
  end

  // stage 1: captured fields
  logic [WHOLE_W-1:0] s1_whole_q [2];
  logic [FRAC_W-1:0]  s1_frac_q [2];
  logic [7:0]         s1_hem_q [2];
  // stage 2: degrees
  logic [WHOLE_W-1:0] s2_whole_q [2];
  logic [DEG_W-1:0]   s2_deg_q [2];
  logic [FRAC_W-1:0]  s2_frac_q [2];
  logic [7:0]         s2_hem_q [2];
  // stage 3: minutes, degrees scaled
  logic [MIN_W-1:0]   s3_min_q [2];
  logic [MAG_W-1:0]   s3_dege7_q [2];
  logic [FRAC_W-1:0]  s3_frac_q [2];
  logic [7:0]         s3_hem_q [2];
  // stage 4: minutes * 1e7
  logic [NUM_W-1:0]   s4_num_q [2];
  logic [MAG_W-1:0]   s4_dege7_q [2];
  logic [7:0]         s4_hem_q [2];
  // stage 5: minutes / 60
  logic [MINQ_W-1:0]  s5_minq_q [2];
  logic [MAG_W-1:0]   s5_dege7_q [2];
  logic [7:0]         s5_hem_q [2];
  // stage 6: magnitude
  logic [MAG_W-1:0]   s6_mag_q [2];
  logic [7:0]         s6_hem_q [2];
  // output register
  logic [OUT_W-1:0]   o_pos_q [2];
  logic [7:0]         o_hem_q [2];
  logic               o_fix_q;

  logic [34:0] deg_prod [2];
  logic [16:0] min_diff [2];
  logic [60:0] q_prod [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      deg_prod[i] = 35'(s1_whole_q[i]) * 35'(RECIP_100);
      min_diff[i] = s2_whole_q[i] - 17'(s2_deg_q[i]) * 17'd100;
      q_prod[i]   = 61'(s4_num_q[i]) * 61'(RECIP_60);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      for (int i = 0; i < 2; i++) begin
        s1_whole_q[i] <= whole_q[i];
        s1_frac_q[i]  <= frac_q[i];
        s1_hem_q[i]   <= hem_q[i];
      end
    end
    if (mv[0]) begin
      for (int i = 0; i < 2; i++) begin
        s2_whole_q[i] <= s1_whole_q[i];
        s2_deg_q[i]   <= deg_prod[i][33:24];
        s2_frac_q[i]  <= s1_frac_q[i];
        s2_hem_q[i]   <= s1_hem_q[i];
      end
    end
    if (mv[1]) begin
      for (int i = 0; i < 2; i++) begin
        s3_min_q[i]   <= min_diff[i][MIN_W-1:0];
        s3_dege7_q[i] <= MAG_W'(s2_deg_q[i]) * MAG_W'(E7);
        s3_frac_q[i]  <= s2_frac_q[i];
        s3_hem_q[i]   <= s2_hem_q[i];
      end
    end
    if (mv[2]) begin
      for (int i = 0; i < 2; i++) begin
        s4_num_q[i]   <= NUM_W'(s3_min_q[i]) * NUM_W'(E7) +
                         NUM_W'(s3_frac_q[i]) * NUM_W'(FRAC_SCALE);
        s4_dege7_q[i] <= s3_dege7_q[i];
        s4_hem_q[i]   <= s3_hem_q[i];
      end
    end
    if (mv[3]) begin
      for (int i = 0; i < 2; i++) begin
        s5_minq_q[i]  <= q_prod[i][59:36];
        s5_dege7_q[i] <= s4_dege7_q[i];
        s5_hem_q[i]   <= s4_hem_q[i];
      end
    end
    if (mv[4]) begin
      for (int i = 0; i < 2; i++) begin
        s6_mag_q[i] <= s5_dege7_q[i] + MAG_W'(s5_minq_q[i]);
        s6_hem_q[i] <= s5_hem_q[i];
      end
    end
    if (mv[5]) begin
      // S and W flip the sign
      o_pos_q[0] <= (s6_hem_q[0] == CHAR_SOUTH) ? -OUT_W'(s6_mag_q[0]) : OUT_W'(s6_mag_q[0]);
      o_pos_q[1] <= (s6_hem_q[1] == CHAR_WEST)  ? -OUT_W'(s6_mag_q[1]) : OUT_W'(s6_mag_q[1]);
      o_hem_q    <= s6_hem_q;
      o_fix_q    <= (s6_mag_q[0] != '0) && (s6_mag_q[1] != '0);
    end
  end

  assign out_valid_o      = sv_q[NST-1];
  assign latitude_e7_o    = $signed(o_pos_q[0]);
  assign longitude_e7_o   = $signed(o_pos_q[1]);
  assign lat_hemisphere_o = o_hem_q[0];
  assign lon_hemisphere_o = o_hem_q[1];
  assign has_fix_o        = o_fix_q;

endmodule

@@ dv/nmea_gga_fix_checker.sv @@
module nmea_gga_fix_checker #(
  parameter int unsigned LINE_CAPACITY   = 128,
  parameter int unsigned FIELD_CHARS     = 19,
  parameter int unsigned FRACTION_DIGITS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [34:0] latitude_e7_i,
  input  logic signed [34:0] longitude_e7_i,
  input  logic [7:0]         lat_hemisphere_i,
  input  logic [7:0]         lon_hemisphere_i,
  input  logic               has_fix_i,
  output int unsigned        errors_o,
  output int unsigned        waiting_o
);
  import nggp_pkg::*;

  localparam longint unsigned DEG_E7 = 64'd10000000;
  localparam logic [47:0] GGA_TAGS [3] = '{"$GPGGA", "$BDGGA", "$GNGGA"};

  typedef struct packed {
    logic [34:0] lat;
    logic [34:0] lon;
    logic [7:0]  lat_h;
    logic [7:0]  lon_h;
    logic        fix;
  } fix_report_t;

  fix_report_t awaited_fixes[$];
  int unsigned mismatches = 0;

  // line state
  int unsigned kept;
  logic [2:0]  tag_alive;
  logic [2:0]  commas;
  logic [4:0]  flen;
  logic [1:0]  phase;
  logic [16:0] lat_w, lat_f, lon_w, lon_f;
  logic [2:0]  lat_n, lon_n;
  logic [7:0]  lat_h, lon_h;

  function automatic void clear_line();
    kept      = 0;
    tag_alive = 3'b111;
    commas    = '0;
    flen      = '0;
    phase     = PH_WHOLE;
    lat_w     = '0;
    lat_f     = '0;
    lat_n     = '0;
    lon_w     = '0;
    lon_f     = '0;
    lon_n     = '0;
    lat_h     = '0;
    lon_h     = '0;
  endfunction

  // deg*1e7 + floor(minutes*1e7/60), minutes held as scaled integer
  function automatic longint unsigned degrees_e7(input logic [16:0] whole,
                                                  input logic [16:0] frac,
                                                  input logic [2:0] ndig);
    longint unsigned scale;
    longint unsigned f;
    longint unsigned mins;
    scale = 1;
    f     = frac;
    for (int i = 0; i < FRACTION_DIGITS; i++) begin
      scale *= 10;
      if (i >= ndig) f *= 10;
    end
    mins = ((longint'(whole) % 100) * scale + f) * DEG_E7;
    return (longint'(whole) / 100) * DEG_E7 + mins / (60 * scale);
  endfunction

  task automatic read_coord_char(input logic [7:0] c, inout logic [16:0] whole,
                                 inout logic [16:0] frac, inout logic [2:0] ndig);
    int unsigned grown;
    logic        is_digit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (phase)
      PH_WHOLE: begin
        if (is_digit) begin
          grown = whole * 10 + (c - CHAR_ZERO);
          whole = (grown > WHOLE_LIMIT) ? WHOLE_LIMIT : 17'(grown);
        end else if (c == CHAR_POINT) begin
          phase = PH_FRAC;
        end else begin
          phase = PH_STOP;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          if (ndig < FRACTION_DIGITS) begin
            frac = 17'(frac * 10 + (c - CHAR_ZERO));
            ndig++;
          end
        end else begin
          phase = PH_STOP;
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_char(input logic [7:0] c);
    int unsigned     pos;
    fix_report_t     rpt;
    longint unsigned lat_mag;
    longint unsigned lon_mag;
    if (c == CHAR_CR || c == CHAR_LF) begin
      if (kept != 0) begin
        if (tag_alive != 0 && kept >= PREFIX_LEN && commas >= MAX_COMMAS) begin
          lat_mag   = degrees_e7(lat_w, lat_f, lat_n);
          lon_mag   = degrees_e7(lon_w, lon_f, lon_n);
          rpt.lat   = (lat_h == CHAR_SOUTH) ? 35'(0 - lat_mag) : 35'(lat_mag);
          rpt.lon   = (lon_h == CHAR_WEST) ? 35'(0 - lon_mag) : 35'(lon_mag);
          rpt.lat_h = lat_h;
          rpt.lon_h = lon_h;
          rpt.fix   = (lat_mag != 0) && (lon_mag != 0);
          awaited_fixes.push_back(rpt);
        end
        clear_line();
      end
    end else if (kept < LINE_CAPACITY - 1) begin
      pos = kept;
      kept++;
      if (pos < PREFIX_LEN) begin
        for (int k = 0; k < NUM_PREFIX; k++)
          if (c != GGA_TAGS[k][47 - 8 * pos -: 8]) tag_alive[k] = 1'b0;
      end
      if (flen == 0) begin
        if (commas == LAT_HEM_COMMA) lat_h = c;
        else if (commas == LON_HEM_COMMA) lon_h = c;
      end
      if (c == CHAR_COMMA) begin
        if (commas < MAX_COMMAS) commas++;
        flen  = '0;
        phase = PH_WHOLE;
      end else begin
        if (flen < FIELD_CHARS) begin
          if (commas == LAT_COMMA) read_coord_char(c, lat_w, lat_f, lat_n);
          else if (commas == LON_COMMA) read_coord_char(c, lon_w, lon_f, lon_n);
        end
        if (flen < FIELD_SAT) flen++;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_fix();
    fix_report_t want;
    if (awaited_fixes.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, actual lat %0d lon %0d",
               $time, latitude_e7_i, longitude_e7_i);
    end else begin
      want = awaited_fixes.pop_front();
      compare_field("latitude_e7", $signed(want.lat), latitude_e7_i);
      compare_field("longitude_e7", $signed(want.lon), longitude_e7_i);
      compare_field("lat_hemisphere", want.lat_h, lat_hemisphere_i);
      compare_field("lon_hemisphere", want.lon_h, lon_hemisphere_i);
      compare_field("has_fix", want.fix, has_fix_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      awaited_fixes.delete();
      errors_o  <= 0;
      waiting_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) take_char(rx_byte_i);
      if (out_valid_i && out_ready_i) check_fix();
      errors_o  <= mismatches;
      waiting_o <= awaited_fixes.size();
    end
  end

endmodule

@@ dv/nmea_gga_position_parser_tb.sv @@
// Stimulus and verdict for the GGA position parser. Characters go in one
// item per handshake; the checker beside the block predicts every position
// report and compares it. This module only builds lines, throttles both
// channels and calls the result.
module nmea_gga_position_parser_tb;
  import nggp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 920;   // rough size of the random part
  localparam int unsigned IDLE_PCT     = 12;    // per-cycle idle chance, both sides
  localparam int unsigned HOLD_CYCLES  = 1200;  // sink hold-off, fills the pipe
  localparam int unsigned CALM_FROM    = 100;   // window with no idling at all
  localparam int unsigned CALM_TO      = 500;
  localparam int unsigned DRAIN_CYCLES = 20;    // conversion pipe is 7 deep
  localparam int unsigned RUN_LIMIT    = 200000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [7:0]        rx_byte_i   = '0;
  logic              out_ready_i = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic signed [34:0] latitude_e7_o;
  logic signed [34:0] longitude_e7_o;
  logic [7:0]        lat_hemisphere_o;
  logic [7:0]        lon_hemisphere_o;
  logic              has_fix_o;

  int unsigned errors;
  int unsigned waiting;
  int unsigned cycle_cnt   = 0;
  int unsigned held        = 0;
  int unsigned chars_sent  = 0;
  logic        hold_start  = 1'b0;
  logic        calm;
  logic [7:0]  line_q[$];   // the line being built, sent as a whole

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;
  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  nmea_gga_position_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .latitude_e7_o   (latitude_e7_o),
    .longitude_e7_o  (longitude_e7_o),
    .lat_hemisphere_o(lat_hemisphere_o),
    .lon_hemisphere_o(lon_hemisphere_o),
    .has_fix_o       (has_fix_o)
  );

  nmea_gga_fix_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .latitude_e7_i   (latitude_e7_o),
    .longitude_e7_i  (longitude_e7_o),
    .lat_hemisphere_i(lat_hemisphere_o),
    .lon_hemisphere_i(lon_hemisphere_o),
    .has_fix_i       (has_fix_o),
    .errors_o        (errors),
    .waiting_o       (waiting)
  );

  // Sink side. One long hold-off once the random part starts, so the
  // sender keeps pushing lines until every conversion stage is full and
  // in_ready_o drops; otherwise random stalls, none inside the calm window.
  always @(posedge clk_i) begin
    if (hold_start && held < HOLD_CYCLES) begin
      out_ready_i <= 1'b0;
      held++;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One character per item. Valid stays up with the byte unchanged until
  // taken; gaps only come between items.
  task automatic send_char(input logic [7:0] c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    chars_sent += line_q.size();
    line_q.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic send_text_line(input string body, input logic [7:0] term);
    put_text(body);
    line_q.push_back(term);
    send_line();
  endtask

  task automatic put_digits(input int unsigned n);
    repeat (n) line_q.push_back(CHAR_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic put_tag();
    case ($urandom_range(2))
      0:       put_text("$GPGGA");
      1:       put_text("$BDGGA");
      default: put_text("$GNGGA");
    endcase
  endtask

  // CR, LF, or CR LF (the LF then closes an empty line)
  task automatic end_line();
    case ($urandom_range(2))
      0:       line_q.push_back(CHAR_CR);
      1:       line_q.push_back(CHAR_LF);
      default: begin
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
      end
    endcase
  endtask

  // ddmm.mmmm with random shape: empty, plain, junk inside, or over-long
  task automatic put_coord();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind == 0) begin
      return;
    end else if (kind <= 6) begin
      put_digits(($urandom_range(4) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5));
      if ($urandom_range(3) != 0) begin
        line_q.push_back(CHAR_POINT);
        put_digits($urandom_range(0, 8));
      end
    end else if (kind == 7) begin
      put_digits($urandom_range(0, 4));
      line_q.push_back(8'($urandom_range(255)));
      put_digits($urandom_range(0, 4));
    end else begin
      put_digits($urandom_range(6, 12));
      line_q.push_back(CHAR_POINT);
      put_digits($urandom_range(6, 14));
    end
  endtask

  // usual letter, negating letter, empty field, or any byte
  task automatic put_hemi(input logic [7:0] pos_c, input logic [7:0] neg_c);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) line_q.push_back(pos_c);
    else if (pick < 8) line_q.push_back(neg_c);
    else if (pick == 9) line_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic put_position();
    line_q.push_back(CHAR_COMMA);
    put_digits($urandom_range(0, 6));
    line_q.push_back(CHAR_COMMA);
    put_coord();
    line_q.push_back(CHAR_COMMA);
    put_hemi("N", CHAR_SOUTH);
    line_q.push_back(CHAR_COMMA);
    put_coord();
    line_q.push_back(CHAR_COMMA);
    put_hemi("E", CHAR_WEST);
  endtask

  // A broken line may get a damaged tag and may be cut short.
  task automatic add_gga_line(input bit broken);
    int unsigned cut;
    put_tag();
    put_position();
    if ($urandom_range(3) != 0) put_text(",1,08,0.9,545.4,M,46.9,M,,*47");
    else line_q.push_back(CHAR_COMMA);
    if (broken) begin
      if ($urandom_range(1) == 1) line_q[$urandom_range(PREFIX_LEN - 1)] = 8'($urandom_range(255));
      if ($urandom_range(1) == 1) begin
        cut = $urandom_range(1, line_q.size());
        while (line_q.size() > cut) void'(line_q.pop_back());
      end
    end
    end_line();
  endtask

  initial begin
    int unsigned pick;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines.
    // typical fix, followed by an empty line from the trailing LF
    send_text_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47",
                   CHAR_CR);
    send_text_line("", CHAR_LF);
    // south and west negate; fraction digits past five ignored; exactly six commas
    send_text_line("$BDGGA,,3345.12345678,S,11820.5,W,", CHAR_LF);
    // every field empty, hemisphere bytes are commas, no fix
    send_text_line("$GNGGA,,,,,,", CHAR_CR);
    // whole part saturates
    send_text_line("$GNGGA,,9999999.999999,S,99999.99999,W,1", CHAR_LF);
    // second point stops the reading; leading sign reads as zero
    send_text_line("$GPGGA,,12.3.4,N,-5,E, 7,x", CHAR_LF);
    // short, foreign and too-few-commas lines; then a full line with a tiny latitude
    send_text_line("$GPG", CHAR_CR);
    send_text_line("$GPRMC,,,,,,,", CHAR_LF);
    send_text_line("$GPGGA,,1,N,2", CHAR_LF);
    send_text_line("$GNGGA,,0000.00001,N,18000.0,E,,", CHAR_LF);
    // fields longer than the read window
    send_text_line("$GPGGA,,1234567890123456789012.5,S,00012.3456789012345678,W,", CHAR_CR);
    // zero and all-ones bytes as hemisphere characters
    put_text("$GPGGA,,4807,");
    line_q.push_back(8'h00);
    put_text(",01131,");
    line_q.push_back(8'hFF);
    send_text_line(",", CHAR_LF);
    // long line whose sixth comma falls in the dropped tail: no result
    put_text("$GPGGA,,4807.5,N,01131.25,E");
    repeat (110) line_q.push_back("A");
    send_text_line(",,,", CHAR_LF);
    // long line with six commas early on: result despite the dropped tail
    put_text("$GNGGA,,4807.5,S,01131.25,W,");
    put_digits(120);
    send_text_line("", CHAR_CR);

    // Random part, sink hold-off starts here.
    hold_start <= 1'b1;
    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        add_gga_line(1'b0);
      end else if (pick < 85) begin
        add_gga_line(1'b1);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 30)) line_q.push_back(8'($urandom_range(255)));
        end_line();
      end else begin
        put_tag();
        put_position();
        line_q.push_back(CHAR_COMMA);
        repeat ($urandom_range(100, 140)) line_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end_line();
      end
      send_line();
    end
    in_valid_i <= 1'b0;

    // the checker's count is registered and lags its queue
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/nggp_pkg.sv
src/nmea_gga_position_parser.sv
dv/nmea_gga_fix_checker.sv
dv/nmea_gga_position_parser_tb.sv
